// File: sv/raft_pkg.sv
package raft_pkg;

  // Field widths.
  localparam int TERM_W     = 31;
  localparam int ROLE_W     = 2;
  localparam int OPCODE_W   = 2;
  localparam int TALLY_W    = 5;
  localparam int ELAPSED_W  = 11;
  localparam int DRAW_W     = 10;
  localparam int RAW_ID_W   = 8;
  localparam int PEER_W     = 4;
  localparam int PEER_CALC_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Parameter defaults.
  localparam int DEF_ID_BITS   = 8;
  localparam int DEF_MAX_PEERS = 15;

  // Saturation limits and reset values.
  localparam logic [TERM_W-1:0]    TERM_MAX    = '1;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [TALLY_W-1:0]   TALLY_MAX   = '1;
  localparam logic [DRAW_W-1:0]    HB_RESET    = 10'd100;

  // Role codes.
  localparam logic [ROLE_W-1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_LEADER    = 2'd2;

  // Opcodes.
  localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_VOTE_REQ = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_APPEND   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_REPLY    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HB_IVL     = 2'd2;

  // One input word.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [TERM_W-1:0]   msg_term;
    logic [RAW_ID_W-1:0] sender_id;
    logic [DRAW_W-1:0]   timeout_draw;
    logic                reply_to_vote;
    logic                reply_granted;
  } item_t;

  // One result word.
  typedef struct packed {
    logic              accepted;
    logic [ROLE_W-1:0] role;
    logic [TERM_W-1:0] term_now;
    logic              send_vote_requests;
    logic              send_beats;
  } result_t;

  // Election state apart from the stored vote identifier.
  typedef struct packed {
    logic [ROLE_W-1:0]    role;
    logic [TERM_W-1:0]    term;
    logic                 vote_cast;
    logic [TALLY_W-1:0]   tally;
    logic [ELAPSED_W-1:0] elapsed;
  } elect_state_t;

endpackage

// File: sv/raft_step.sv
module raft_step #(
  parameter int ID_BITS   = raft_pkg::DEF_ID_BITS,
  parameter int MAX_PEERS = raft_pkg::DEF_MAX_PEERS
) (
  input  raft_pkg::elect_state_t            cur_i,
  input  logic [ID_BITS-1:0]                voted_id_i,
  input  raft_pkg::item_t                   item_i,
  input  logic [raft_pkg::RAW_ID_W-1:0]     own_id_i,
  input  logic [raft_pkg::PEER_W-1:0]       peer_count_i,
  input  logic [raft_pkg::DRAW_W-1:0]       hb_ivl_i,
  output raft_pkg::elect_state_t            nxt_o,
  output logic [ID_BITS-1:0]                voted_id_o,
  output raft_pkg::result_t                 res_o
);

  localparam int EW = raft_pkg::ELAPSED_W;
  localparam int PW = raft_pkg::PEER_CALC_W;
  localparam int TW = raft_pkg::TALLY_W;
  localparam int RW = raft_pkg::RAW_ID_W;

  logic [EW-1:0]         elapsed_inc;
  logic [ID_BITS+RW-1:0] sender_ext;
  logic [ID_BITS+RW-1:0] own_ext;
  logic [ID_BITS-1:0]    sender_id;
  logic [ID_BITS-1:0]    own_id;
  logic [PW-1:0]         peers_raw;
  logic [PW-1:0]         peers_used;
  logic [PW-1:0]         quorum_half;
  logic [TW-1:0]         tally_inc;
  logic                  term_higher;
  logic                  term_equal;
  logic                  accepted;
  logic                  req_votes;
  logic                  req_beats;

  // Identifiers are cut or widened to the configured identifier width.
  assign sender_ext = {{ID_BITS{1'b0}}, item_i.sender_id};
  assign own_ext    = {{ID_BITS{1'b0}}, own_id_i};
  assign sender_id  = sender_ext[ID_BITS-1:0];
  assign own_id     = own_ext[ID_BITS-1:0];

  // Peer count clamped to the cluster limit, and half of the cluster size.
  assign peers_raw   = PW'(peer_count_i);
  assign peers_used  = (peers_raw > PW'(MAX_PEERS)) ? PW'(MAX_PEERS) : peers_raw;
  assign quorum_half = (peers_used + PW'(1)) >> 1;

  // Saturating counters.
  assign elapsed_inc = (cur_i.elapsed == raft_pkg::ELAPSED_MAX) ?
                       cur_i.elapsed : cur_i.elapsed + EW'(1);
  assign tally_inc   = (cur_i.tally == raft_pkg::TALLY_MAX) ?
                       cur_i.tally : cur_i.tally + TW'(1);

  assign term_higher = item_i.msg_term > cur_i.term;
  assign term_equal  = item_i.msg_term == cur_i.term;

  // Next state and broadcast requests for one word.
  always_comb begin
    nxt_o      = cur_i;
    voted_id_o = voted_id_i;
    accepted   = 1'b0;
    req_votes  = 1'b0;
    req_beats  = 1'b0;
    unique case (item_i.opcode)
      raft_pkg::OP_TICK: begin
        nxt_o.elapsed = elapsed_inc;
        if (cur_i.role == raft_pkg::ROLE_LEADER) begin
          if (elapsed_inc >= EW'(hb_ivl_i)) begin
            req_beats     = 1'b1;
            nxt_o.elapsed = '0;
          end
        end else if (elapsed_inc >= EW'(item_i.timeout_draw)) begin
          // Start an election: vote for ourselves in the next term.
          nxt_o.role      = raft_pkg::ROLE_CANDIDATE;
          nxt_o.term      = (cur_i.term == raft_pkg::TERM_MAX) ?
                            cur_i.term : cur_i.term + raft_pkg::TERM_W'(1);
          nxt_o.vote_cast = 1'b1;
          voted_id_o      = own_id;
          nxt_o.tally     = TW'(1);
          nxt_o.elapsed   = '0;
          if (peers_used == '0) begin
            nxt_o.role = raft_pkg::ROLE_LEADER;
          end else begin
            req_votes = 1'b1;
          end
        end
      end
      raft_pkg::OP_VOTE_REQ: begin
        if (!(item_i.msg_term < cur_i.term)) begin
          if (term_higher) begin
            nxt_o.term      = item_i.msg_term;
            nxt_o.role      = raft_pkg::ROLE_FOLLOWER;
            nxt_o.vote_cast = 1'b0;
          end
          if (!nxt_o.vote_cast || (voted_id_i == sender_id)) begin
            nxt_o.vote_cast = 1'b1;
            voted_id_o      = sender_id;
            nxt_o.elapsed   = '0;
            accepted        = 1'b1;
          end
        end
      end
      raft_pkg::OP_APPEND: begin
        if (!(item_i.msg_term < cur_i.term)) begin
          if (term_higher) begin
            nxt_o.vote_cast = 1'b0;
          end
          nxt_o.term    = item_i.msg_term;
          nxt_o.role    = raft_pkg::ROLE_FOLLOWER;
          nxt_o.elapsed = '0;
          accepted      = 1'b1;
        end
      end
      raft_pkg::OP_REPLY: begin
        if (term_higher) begin
          nxt_o.term      = item_i.msg_term;
          nxt_o.role      = raft_pkg::ROLE_FOLLOWER;
          nxt_o.vote_cast = 1'b0;
        end else if (item_i.reply_to_vote && item_i.reply_granted && term_equal) begin
          // Count the vote; a majority makes a candidate the leader.
          nxt_o.tally = tally_inc;
          if ((cur_i.role == raft_pkg::ROLE_CANDIDATE) &&
              (PW'(tally_inc) > quorum_half)) begin
            nxt_o.role = raft_pkg::ROLE_LEADER;
            req_beats  = 1'b1;
          end
        end
      end
    endcase
  end

  // Result word.
  always_comb begin
    res_o.accepted           = accepted;
    res_o.role               = nxt_o.role;
    res_o.term_now           = nxt_o.term;
    res_o.send_vote_requests = req_votes;
    res_o.send_beats         = req_beats;
  end

endmodule

// File: sv/raft_election_state_machine.sv
// Single-node Raft leader election. Each input word (tick, vote request,
// append/heartbeat or peer reply) yields exactly one result word carrying the
// grant flag, the role and term after the word, and broadcast requests. The
// block takes one word per cycle while the output side does not stall: a word
// is captured in the input register, and once the output register is free the
// election state is updated and the result is written to the output register.
// The state update of one word feeds the next word directly, which keeps the
// rate at one word per clock while results are taken. Configuration
// registers should be written only while no word is in flight.
module raft_election_state_machine #(
  parameter int ID_BITS   = raft_pkg::DEF_ID_BITS,
  parameter int MAX_PEERS = raft_pkg::DEF_MAX_PEERS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration port.
  input  logic                               cfg_we,
  input  logic [raft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [raft_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // Input channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [raft_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [raft_pkg::TERM_W-1:0]        in_msg_term,
  input  logic [raft_pkg::RAW_ID_W-1:0]      in_sender_id,
  input  logic [raft_pkg::DRAW_W-1:0]        in_timeout_draw,
  input  logic                               in_reply_to_vote,
  input  logic                               in_reply_granted,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_accepted,
  output logic [raft_pkg::ROLE_W-1:0]        out_role,
  output logic [raft_pkg::TERM_W-1:0]        out_term_now,
  output logic                               out_send_vote_requests,
  output logic                               out_send_beats
);

  raft_pkg::item_t                   item_r;
  logic                              in_vld_r;
  logic                              in_vld_nxt;
  raft_pkg::result_t                 res_r;
  raft_pkg::result_t                 res_nxt;
  logic                              out_vld_r;
  logic                              out_vld_nxt;
  raft_pkg::elect_state_t            state_r;
  raft_pkg::elect_state_t            state_nxt;
  logic [ID_BITS-1:0]                voted_id_r;
  logic [ID_BITS-1:0]                voted_id_nxt;
  logic [raft_pkg::RAW_ID_W-1:0]     own_id_r;
  logic [raft_pkg::PEER_W-1:0]       peer_count_r;
  logic [raft_pkg::DRAW_W-1:0]       hb_ivl_r;
  logic                              load;
  logic                              advance;

  // Handshake: the held word advances whenever the output register frees up.
  assign advance    = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready   = !in_vld_r || advance;
  assign load       = in_valid && in_ready;
  assign in_vld_nxt = load || (in_vld_r && !advance);
  assign out_vld_nxt = advance || (out_vld_r && !out_ready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r     <= '0;
      peer_count_r <= '0;
      hb_ivl_r     <= raft_pkg::HB_RESET;
    end else if (cfg_we) begin
      if (cfg_index == raft_pkg::CFG_OWN_ID) begin
        own_id_r <= cfg_wdata[raft_pkg::RAW_ID_W-1:0];
      end
      if (cfg_index == raft_pkg::CFG_PEER_COUNT) begin
        peer_count_r <= cfg_wdata[raft_pkg::PEER_W-1:0];
      end
      if (cfg_index == raft_pkg::CFG_HB_IVL) begin
        hb_ivl_r <= cfg_wdata;
      end
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Input word register.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.opcode        <= in_opcode;
      item_r.msg_term      <= in_msg_term;
      item_r.sender_id     <= in_sender_id;
      item_r.timeout_draw  <= in_timeout_draw;
      item_r.reply_to_vote <= in_reply_to_vote;
      item_r.reply_granted <= in_reply_granted;
    end
  end

  // Election step logic.
  raft_step #(
    .ID_BITS   (ID_BITS),
    .MAX_PEERS (MAX_PEERS)
  ) u_step (
    .cur_i        (state_r),
    .voted_id_i   (voted_id_r),
    .item_i       (item_r),
    .own_id_i     (own_id_r),
    .peer_count_i (peer_count_r),
    .hb_ivl_i     (hb_ivl_r),
    .nxt_o        (state_nxt),
    .voted_id_o   (voted_id_nxt),
    .res_o        (res_nxt)
  );

  // Election state commits as the word moves to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.role      <= raft_pkg::ROLE_FOLLOWER;
      state_r.term      <= '0;
      state_r.vote_cast <= 1'b0;
      state_r.tally     <= '0;
      state_r.elapsed   <= '0;
      voted_id_r        <= '0;
    end else if (advance) begin
      state_r    <= state_nxt;
      voted_id_r <= voted_id_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = out_vld_r;
  assign out_accepted           = res_r.accepted;
  assign out_role               = res_r.role;
  assign out_term_now           = res_r.term_now;
  assign out_send_vote_requests = res_r.send_vote_requests;
  assign out_send_beats         = res_r.send_beats;

  // A candidate always holds at least its own vote.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.role == raft_pkg::ROLE_CANDIDATE) |-> (state_r.tally != '0))
    else $error("candidate with empty vote tally");

  // The current term never goes backward.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (state_r.term >= $past(state_r.term)))
    else $error("current term decreased");

  // Vote requests go out only from a candidate.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.send_vote_requests) |->
      (res_r.role == raft_pkg::ROLE_CANDIDATE && !res_r.send_beats))
    else $error("vote request broadcast outside candidate role");

endmodule

// File: dv/raft_election_state_machine_tb.sv
module raft_election_state_machine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 14;
  localparam int WORDS_PER_PHASE = 125;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            cfg_we = 1'b0;
  logic [raft_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [raft_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [raft_pkg::OPCODE_W-1:0] in_opcode = raft_pkg::OP_TICK;
  logic [raft_pkg::TERM_W-1:0]   in_msg_term = '0;
  logic [raft_pkg::RAW_ID_W-1:0] in_sender_id = '0;
  logic [raft_pkg::DRAW_W-1:0]   in_timeout_draw = '0;
  logic                          in_reply_to_vote = 1'b0;
  logic                          in_reply_granted = 1'b0;

  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_accepted;
  logic [raft_pkg::ROLE_W-1:0] out_role;
  logic [raft_pkg::TERM_W-1:0] out_term_now;
  logic                        out_send_vote_requests;
  logic                        out_send_beats;

  // Predicted election state and configuration of the node.
  logic [raft_pkg::ROLE_W-1:0]    st_role = raft_pkg::ROLE_FOLLOWER;
  logic [raft_pkg::TERM_W-1:0]    st_term = '0;
  logic                           st_voted = 1'b0;
  logic [raft_pkg::RAW_ID_W-1:0]  st_voter = '0;
  logic [raft_pkg::TALLY_W-1:0]   st_tally = '0;
  logic [raft_pkg::ELAPSED_W-1:0] st_elapsed = '0;
  logic [raft_pkg::RAW_ID_W-1:0]  cf_own_id = '0;
  logic [raft_pkg::PEER_W-1:0]    cf_peers = '0;
  logic [raft_pkg::DRAW_W-1:0]    cf_ivl = raft_pkg::HB_RESET;

  raft_pkg::result_t awaited_outcomes[$];
  int                mismatches = 0;
  int                cycle_count = 0;
  bit                steady = 1'b0;

  typedef struct {
    raft_pkg::item_t   w;
    bit                typed;
    raft_pkg::result_t want;
  } script_row_t;

  script_row_t script[$];

  raft_election_state_machine uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_opcode              (in_opcode),
    .in_msg_term            (in_msg_term),
    .in_sender_id           (in_sender_id),
    .in_timeout_draw        (in_timeout_draw),
    .in_reply_to_vote       (in_reply_to_vote),
    .in_reply_granted       (in_reply_granted),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_accepted           (out_accepted),
    .out_role               (out_role),
    .out_term_now           (out_term_now),
    .out_send_vote_requests (out_send_vote_requests),
    .out_send_beats         (out_send_beats)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // A higher term makes the node a follower with no vote in the new term.
  function automatic void adopt_term(logic [raft_pkg::TERM_W-1:0] t);
    st_term = t;
    st_role = raft_pkg::ROLE_FOLLOWER;
    st_voted = 1'b0;
  endfunction

  // Advances the predicted node by one word and returns the outcome it owes.
  function automatic raft_pkg::result_t advance_election(raft_pkg::item_t w);
    raft_pkg::result_t r;
    r = '0;
    case (w.opcode)
      raft_pkg::OP_TICK: begin
        if (st_elapsed != raft_pkg::ELAPSED_MAX) st_elapsed = st_elapsed + 1'b1;
        if (st_role == raft_pkg::ROLE_LEADER) begin
          if (st_elapsed >= cf_ivl) begin
            r.send_beats = 1'b1;
            st_elapsed = '0;
          end
        end else if (st_elapsed >= w.timeout_draw) begin
          // Start an election; a node without peers wins it on the spot.
          st_role = raft_pkg::ROLE_CANDIDATE;
          if (st_term != raft_pkg::TERM_MAX) st_term = st_term + 1'b1;
          st_voted = 1'b1;
          st_voter = cf_own_id;
          st_tally = 5'd1;
          st_elapsed = '0;
          if (cf_peers == '0) st_role = raft_pkg::ROLE_LEADER;
          else r.send_vote_requests = 1'b1;
        end
      end
      raft_pkg::OP_VOTE_REQ: begin
        if (w.msg_term >= st_term) begin
          if (w.msg_term > st_term) adopt_term(w.msg_term);
          if (!st_voted || st_voter == w.sender_id) begin
            st_voted = 1'b1;
            st_voter = w.sender_id;
            st_elapsed = '0;
            r.accepted = 1'b1;
          end
        end
      end
      raft_pkg::OP_APPEND: begin
        if (w.msg_term >= st_term) begin
          if (w.msg_term > st_term) st_voted = 1'b0;
          st_term = w.msg_term;
          st_role = raft_pkg::ROLE_FOLLOWER;
          st_elapsed = '0;
          r.accepted = 1'b1;
        end
      end
      raft_pkg::OP_REPLY: begin
        if (w.msg_term > st_term) begin
          adopt_term(w.msg_term);
        end else if (w.reply_to_vote && w.reply_granted && w.msg_term == st_term) begin
          // Only a granted vote of the current term counts toward a majority.
          if (st_tally != raft_pkg::TALLY_MAX) st_tally = st_tally + 1'b1;
          if (st_role == raft_pkg::ROLE_CANDIDATE &&
              st_tally > (int'(cf_peers) + 1) / 2) begin
            st_role = raft_pkg::ROLE_LEADER;
            r.send_beats = 1'b1;
          end
        end
      end
    endcase
    r.role = st_role;
    r.term_now = st_term;
    return r;
  endfunction

  // Random word, mostly shaped around the current term so that elections,
  // majorities and heartbeats keep happening; the rest is plain noise.
  function automatic raft_pkg::item_t random_word();
    raft_pkg::item_t w;
    int unsigned p;
    w.opcode = raft_pkg::OP_TICK + raft_pkg::OPCODE_W'($urandom_range(3));
    w.sender_id = raft_pkg::RAW_ID_W'($urandom_range(255));
    w.timeout_draw = raft_pkg::DRAW_W'($urandom_range(1023));
    w.reply_to_vote = 1'($urandom_range(1));
    w.reply_granted = 1'($urandom_range(1));
    p = $urandom_range(99);
    if (p < 40) begin
      w.msg_term = st_term;
    end else if (p < 60) begin
      w.msg_term = (st_term == raft_pkg::TERM_MAX) ? st_term : st_term + 1'b1;
    end else if (p < 78) begin
      w.msg_term = (st_term == '0) ? st_term : st_term - 1'b1;
    end else if (p < 96) begin
      w.msg_term = raft_pkg::TERM_W'($urandom_range(40));
    end else begin
      w.msg_term = raft_pkg::TERM_W'($urandom());
    end
    if ($urandom_range(99) >= 12) begin
      p = $urandom_range(99);
      if (p < 35) begin
        w.opcode = raft_pkg::OP_TICK;
        if ($urandom_range(99) < 70) w.timeout_draw = raft_pkg::DRAW_W'($urandom_range(12));
      end else if (p < 50) begin
        w.opcode = raft_pkg::OP_VOTE_REQ;
        if ($urandom_range(1) == 1) w.sender_id = raft_pkg::RAW_ID_W'($urandom_range(3));
      end else if (p < 62) begin
        w.opcode = raft_pkg::OP_APPEND;
      end else begin
        w.opcode = raft_pkg::OP_REPLY;
        if ($urandom_range(99) < 65) begin
          w.reply_to_vote = 1'b1;
          w.reply_granted = 1'b1;
          w.msg_term = st_term;
        end
      end
    end
    return w;
  endfunction

  function automatic void add_row(logic [raft_pkg::OPCODE_W-1:0] op,
                                  logic [raft_pkg::TERM_W-1:0] t,
                                  logic [raft_pkg::RAW_ID_W-1:0] sender,
                                  logic [raft_pkg::DRAW_W-1:0] draw,
                                  logic to_vote, logic granted, bit typed,
                                  raft_pkg::result_t want);
    script_row_t row;
    row.w = '{op, t, sender, draw, to_vote, granted};
    row.typed = typed;
    row.want = want;
    script.insert(script.size(), row);
  endfunction

  // Offers one word, waits for it to be taken, and records its outcome.
  task automatic send_word(raft_pkg::item_t w, bit typed, raft_pkg::result_t want);
    raft_pkg::result_t r;
    if (!steady && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= w.opcode;
    in_msg_term <= w.msg_term;
    in_sender_id <= w.sender_id;
    in_timeout_draw <= w.timeout_draw;
    in_reply_to_vote <= w.reply_to_vote;
    in_reply_granted <= w.reply_granted;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = advance_election(w);
    awaited_outcomes.insert(awaited_outcomes.size(), typed ? want : r);
  endtask

  task automatic play(int first, int last);
    for (int i = first; i <= last; i++) send_word(script[i].w, script[i].typed, script[i].want);
    in_valid <= 1'b0;
  endtask

  // Waits until every outcome is in, then lets the pipeline settle.
  task automatic drain();
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [raft_pkg::CFG_IDX_W-1:0] idx,
                           logic [raft_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      raft_pkg::CFG_OWN_ID:     cf_own_id = val[raft_pkg::RAW_ID_W-1:0];
      raft_pkg::CFG_PEER_COUNT: cf_peers = val[raft_pkg::PEER_W-1:0];
      raft_pkg::CFG_HB_IVL:     cf_ivl = val[raft_pkg::DRAW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [raft_pkg::RAW_ID_W-1:0] id,
                             logic [raft_pkg::PEER_W-1:0] peers,
                             logic [raft_pkg::DRAW_W-1:0] ivl);
    write_reg(raft_pkg::CFG_OWN_ID, raft_pkg::CFG_DATA_W'(id));
    write_reg(raft_pkg::CFG_PEER_COUNT, raft_pkg::CFG_DATA_W'(peers));
    write_reg(raft_pkg::CFG_HB_IVL, ivl);
    cfg_we <= 1'b0;
  endtask

  // The result side stalls in bursts, except in the final stretch.
  initial begin
    forever begin
      if (!steady && $urandom_range(2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Each result word is checked against the oldest outstanding outcome.
  always @(posedge clk) begin : check_side
    raft_pkg::result_t got;
    raft_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_accepted, out_role, out_term_now, out_send_vote_requests,
              out_send_beats};
      if (awaited_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: acc=%0d role=%0d term=%0d votes=%0d beats=%0d",
                   got.accepted, got.role, got.term_now, got.send_vote_requests,
                   got.send_beats);
      end else begin
        want = awaited_outcomes.pop_front();
        if (got.accepted !== want.accepted || got.role !== want.role ||
            got.term_now !== want.term_now ||
            got.send_vote_requests !== want.send_vote_requests ||
            got.send_beats !== want.send_beats) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected acc=%0d role=%0d term=%0d votes=%0d beats=%0d,",
                      " got acc=%0d role=%0d term=%0d votes=%0d beats=%0d"},
                     want.accepted, want.role, want.term_now, want.send_vote_requests,
                     want.send_beats, got.accepted, got.role, got.term_now,
                     got.send_vote_requests, got.send_beats);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [raft_pkg::PEER_W-1:0] peers;
    logic [raft_pkg::DRAW_W-1:0] ivl;

    // Opening rows run with the reset configuration: no peers, interval 100.
    add_row(raft_pkg::OP_TICK, 0, 8'h00, 10'd1023, 0, 0, 1,
            '{0, raft_pkg::ROLE_FOLLOWER, 0, 0, 0});
    add_row(raft_pkg::OP_VOTE_REQ, 0, 8'hFF, 0, 0, 0, 1,
            '{1, raft_pkg::ROLE_FOLLOWER, 0, 0, 0});
    add_row(raft_pkg::OP_VOTE_REQ, 0, 8'h00, 0, 0, 0, 1,
            '{0, raft_pkg::ROLE_FOLLOWER, 0, 0, 0});
    add_row(raft_pkg::OP_VOTE_REQ, 0, 8'hFF, 0, 0, 0, 0, '0);
    add_row(raft_pkg::OP_TICK, 0, 8'h00, 10'd0, 0, 0, 1,
            '{0, raft_pkg::ROLE_LEADER, 1, 0, 0});
    add_row(raft_pkg::OP_TICK, 0, 8'h00, 10'd0, 0, 0, 0, '0);
    add_row(raft_pkg::OP_REPLY, 1, 8'h00, 0, 1, 1, 0, '0);
    add_row(raft_pkg::OP_APPEND, 0, 8'h00, 0, 0, 0, 1,
            '{0, raft_pkg::ROLE_LEADER, 1, 0, 0});
    add_row(raft_pkg::OP_VOTE_REQ, 0, 8'h00, 0, 0, 0, 1,
            '{0, raft_pkg::ROLE_LEADER, 1, 0, 0});
    add_row(raft_pkg::OP_REPLY, 2, 8'h00, 0, 0, 0, 0, '0);
    add_row(raft_pkg::OP_APPEND, 2, 8'h00, 0, 0, 0, 0, '0);
    add_row(raft_pkg::OP_APPEND, 3, 8'h00, 0, 0, 0, 0, '0);
    add_row(raft_pkg::OP_REPLY, 3, 8'h00, 0, 1, 0, 0, '0);
    add_row(raft_pkg::OP_REPLY, 3, 8'h00, 0, 0, 1, 0, '0);
    // Two peers, interval 3: a contested election won by a majority.
    add_row(raft_pkg::OP_TICK, 0, 8'h00, 10'd0, 0, 0, 0, '0);
    add_row(raft_pkg::OP_VOTE_REQ, 4, 8'h07, 0, 0, 0, 0, '0);
    add_row(raft_pkg::OP_REPLY, 3, 8'h00, 0, 1, 1, 0, '0);
    add_row(raft_pkg::OP_REPLY, 4, 8'h00, 0, 1, 1, 0, '0);
    add_row(raft_pkg::OP_TICK, 0, 8'h00, 10'd1023, 0, 0, 0, '0);
    add_row(raft_pkg::OP_TICK, 0, 8'h00, 10'd1023, 0, 0, 0, '0);
    add_row(raft_pkg::OP_TICK, 0, 8'h00, 10'd1023, 0, 0, 0, '0);
    // Closing rows drive the term into saturation, three peers.
    add_row(raft_pkg::OP_APPEND, raft_pkg::TERM_MAX, 8'h00, 0, 0, 0, 1,
            '{1, raft_pkg::ROLE_FOLLOWER, raft_pkg::TERM_MAX, 0, 0});
    add_row(raft_pkg::OP_TICK, 0, 8'h00, 10'd0, 0, 0, 1,
            '{0, raft_pkg::ROLE_CANDIDATE, raft_pkg::TERM_MAX, 1, 0});
    add_row(raft_pkg::OP_VOTE_REQ, raft_pkg::TERM_MAX - 1'b1, 8'h55, 0, 0, 0, 1,
            '{0, raft_pkg::ROLE_CANDIDATE, raft_pkg::TERM_MAX, 0, 0});
    add_row(raft_pkg::OP_REPLY, raft_pkg::TERM_MAX, 8'h00, 0, 1, 1, 0, '0);
    add_row(raft_pkg::OP_REPLY, raft_pkg::TERM_MAX, 8'h00, 0, 1, 1, 0, '0);
    add_row(raft_pkg::OP_TICK, 0, 8'h00, 10'd1023, 0, 0, 0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    play(0, 13);
    drain();
    load_config(8'h2A, 4'd2, 10'd3);
    play(14, 20);
    drain();

    // Random phases, each under its own configuration, extremes first.
    for (int ph = 0; ph < PHASES; ph++) begin
      peers = ($urandom_range(1) == 1) ? raft_pkg::PEER_W'($urandom_range(3)) :
                                         raft_pkg::PEER_W'($urandom_range(15));
      ivl = ($urandom_range(9) < 7) ? raft_pkg::DRAW_W'($urandom_range(1, 8)) :
                                      raft_pkg::DRAW_W'($urandom_range(1, 1023));
      case (ph)
        0: load_config(8'hFF, 4'd15, 10'd1023);
        1: load_config(8'h00, 4'd0, 10'd1);
        2: load_config(8'h01, 4'd1, 10'd0);
        default: load_config(raft_pkg::RAW_ID_W'($urandom_range(255)), peers, ivl);
      endcase
      if (ph == PHASES - 1) steady = 1'b1;
      repeat (WORDS_PER_PHASE) send_word(random_word(), 1'b0, '0);
      in_valid <= 1'b0;
      drain();
    end

    load_config(8'h55, 4'd3, 10'd2);
    play(21, 26);
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
